FILE: src/i4p_pkg.sv
`default_nettype none
package i4p_pkg;

   localparam int BLOCK_SIZE = 4;
   localparam int PIX_W      = 8;
   localparam int ROW_W      = $clog2(BLOCK_SIZE);
   localparam int ABOVE_N    = 2 * BLOCK_SIZE;
   localparam int EDGE_N     = 4 * BLOCK_SIZE;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BLOCK_SIZE - 1);

   // prediction mode codes
   localparam logic [3:0] MODE_DC = 4'd0;
   localparam logic [3:0] MODE_TM = 4'd1;
   localparam logic [3:0] MODE_VE = 4'd2;
   localparam logic [3:0] MODE_HE = 4'd3;
   localparam logic [3:0] MODE_LD = 4'd4;
   localparam logic [3:0] MODE_RD = 4'd5;
   localparam logic [3:0] MODE_VR = 4'd6;
   localparam logic [3:0] MODE_VL = 4'd7;
   localparam logic [3:0] MODE_HD = 4'd8;
   localparam logic [3:0] MODE_HU = 4'd9;

   typedef struct packed {
      logic [3:0]                    mode;
      logic [PIX_W-1:0]              corner;
      logic [ABOVE_N*PIX_W-1:0]      above;
      logic [BLOCK_SIZE*PIX_W-1:0]   left;
   } req_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
   } row_ctl_type;

endpackage
`default_nettype wire

FILE: src/i4p_lane.sv
`default_nettype none
// one column of the predicted row
module i4p_lane import i4p_pkg::*; #(
   parameter int COL = 0
) (
   input  req_type          req,
   input  logic [ROW_W-1:0] row,
   input  logic [PIX_W-1:0] dc,
   output logic [PIX_W-1:0] pixel
);

   typedef enum logic [1:0] {OP_ZERO, OP_DIRECT, OP_AVG2, OP_AVG3} op_type;

   logic [PIX_W-1:0] a_px  [ABOVE_N];
   logic [PIX_W-1:0] l_px  [BLOCK_SIZE];
   logic [PIX_W-1:0] e_px  [EDGE_N];
   logic [PIX_W-1:0] ve_px [ABOVE_N+1];

   logic signed [PIX_W+1:0] tm_sum;
   logic [PIX_W-1:0]        tm_px;
   logic [PIX_W-1:0]        t0, t1, t2, direct;
   op_type                  op;
   logic [PIX_W:0]          s2;
   logic [PIX_W+1:0]        s3;

   // edge line: above reversed, corner, then left with the last left pixel repeated
   always_comb begin
      for (int k = 0; k < ABOVE_N; k++) a_px[k] = req.above[k*PIX_W +: PIX_W];
      for (int k = 0; k < BLOCK_SIZE; k++) l_px[k] = req.left[k*PIX_W +: PIX_W];
      for (int k = 0; k < EDGE_N; k++) e_px[k] = '0;
      e_px[2*BLOCK_SIZE-1] = req.corner;
      for (int k = 0; k < BLOCK_SIZE; k++) begin
         e_px[2*BLOCK_SIZE-2-k] = a_px[k];
         e_px[2*BLOCK_SIZE+k]   = l_px[k];
      end
      for (int k = 3*BLOCK_SIZE; k < EDGE_N; k++) e_px[k] = l_px[BLOCK_SIZE-1];
      ve_px[0] = req.corner;
      for (int k = 0; k < ABOVE_N; k++) ve_px[k+1] = a_px[k];
   end

   // true motion with clamp
   always_comb begin
      tm_sum = signed'({2'b00, a_px[COL]}) + signed'({2'b00, l_px[row]})
             - signed'({2'b00, req.corner});
      if (tm_sum[PIX_W+1]) begin
         tm_px = '0;
      end else if (tm_sum[PIX_W]) begin
         tm_px = '1;
      end else begin
         tm_px = tm_sum[PIX_W-1:0];
      end
   end

   // tap selection
   always_comb begin
      int y, h, b, i, xh;
      logic odd;
      y   = int'(row);
      h   = y / 2;
      odd = row[0];
      xh  = COL / 2;
      b   = 0;
      i   = 0;
      t0  = '0;
      t1  = '0;
      t2  = '0;
      direct = '0;
      op  = OP_ZERO;
      unique case (req.mode)
         MODE_DC: begin
            op = OP_DIRECT;
            direct = dc;
         end
         MODE_TM: begin
            op = OP_DIRECT;
            direct = tm_px;
         end
         MODE_VE: begin
            op = OP_AVG3;
            t0 = ve_px[COL];
            t1 = ve_px[COL+1];
            t2 = ve_px[COL+2];
         end
         MODE_HE: begin
            op = OP_AVG3;
            t0 = e_px[4'(2*BLOCK_SIZE + y - 1)];
            t1 = e_px[4'(2*BLOCK_SIZE + y)];
            t2 = e_px[4'(2*BLOCK_SIZE + y + 1)];
         end
         MODE_LD: begin
            op = OP_AVG3;
            i  = y + COL;
            t0 = a_px[3'(i)];
            t1 = a_px[3'(i + 1)];
            t2 = (i + 2 > ABOVE_N - 1) ? a_px[ABOVE_N-1] : a_px[3'(i + 2)];
         end
         MODE_RD: begin
            op = OP_AVG3;
            b  = 2*BLOCK_SIZE + y - COL;
            t0 = e_px[4'(b)];
            t1 = e_px[4'(b - 1)];
            t2 = e_px[4'(b - 2)];
         end
         MODE_VR: begin
            if (COL < h) begin
               b  = 2*BLOCK_SIZE + 2*h - COL;
               op = OP_AVG3;
               if (odd) begin
                  t0 = e_px[4'(b)];
                  t1 = e_px[4'(b - 1)];
                  t2 = e_px[4'(b - 2)];
               end else begin
                  t0 = e_px[4'(b - 1)];
                  t1 = e_px[4'(b - 2)];
                  t2 = e_px[4'(b - 3)];
               end
            end else begin
               b = 2*BLOCK_SIZE + h - COL;
               if (odd) begin
                  op = OP_AVG3;
                  t0 = e_px[4'(b)];
                  t1 = e_px[4'(b - 1)];
                  t2 = e_px[4'(b - 2)];
               end else begin
                  op = OP_AVG2;
                  t0 = e_px[4'(b - 1)];
                  t1 = e_px[4'(b - 2)];
               end
            end
         end
         MODE_VL: begin
            i  = h + COL;
            t0 = a_px[3'(i)];
            t1 = a_px[3'(i + 1)];
            t2 = a_px[3'(i + 2)];
            op = odd ? OP_AVG3 : OP_AVG2;
         end
         MODE_HD: begin
            if (y < xh) begin
               b  = 2*BLOCK_SIZE + y - 2*xh;
               op = OP_AVG3;
               if (COL % 2 == 1) begin
                  t0 = e_px[4'(b)];
                  t1 = e_px[4'(b - 1)];
                  t2 = e_px[4'(b - 2)];
               end else begin
                  t0 = e_px[4'(b + 1)];
                  t1 = e_px[4'(b)];
                  t2 = e_px[4'(b - 1)];
               end
            end else begin
               b  = 2*BLOCK_SIZE + y - xh;
               if (COL % 2 == 1) begin
                  op = OP_AVG3;
                  t0 = e_px[4'(b)];
                  t1 = e_px[4'(b - 1)];
                  t2 = e_px[4'(b - 2)];
               end else begin
                  op = OP_AVG2;
                  t0 = e_px[4'(b - 1)];
                  t1 = e_px[4'(b)];
               end
            end
         end
         MODE_HU: begin
            b  = 2*BLOCK_SIZE + y + xh;
            t0 = e_px[4'(b)];
            t1 = e_px[4'(b + 1)];
            t2 = e_px[4'(b + 2)];
            op = (COL % 2 == 1) ? OP_AVG3 : OP_AVG2;
         end
         default: begin
            op = OP_ZERO;
         end
      endcase
   end

   // rounded averages
   always_comb begin
      s2 = {1'b0, t0} + {1'b0, t1} + (PIX_W+1)'(1);
      s3 = {2'b00, t0} + {1'b0, t1, 1'b0} + {2'b00, t2} + (PIX_W+2)'(2);
      unique case (op)
         OP_DIRECT: pixel = direct;
         OP_AVG2:   pixel = s2[PIX_W:1];
         OP_AVG3:   pixel = s3[PIX_W+1:2];
         default:   pixel = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/i4p_merge.sv
`default_nettype none
// packs the lane pixels into one row and registers the result
module i4p_merge import i4p_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  row_ctl_type                       ctl,
   input  logic [BLOCK_SIZE-1:0][PIX_W-1:0]  lane_pix,
   output logic                              rsp_strobe,
   output logic [ROW_W-1:0]                  rsp_row_index,
   output logic [BLOCK_SIZE*PIX_W-1:0]       rsp_row_pixels,
   output logic                              rsp_last_row
);

   logic                        strobe_ff;
   logic [ROW_W-1:0]            row_ff;
   logic [BLOCK_SIZE*PIX_W-1:0] pix_ff;
   logic                        last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.valid;
      end
      row_ff  <= ctl.row;
      pix_ff  <= lane_pix;
      last_ff <= (ctl.row == LAST_ROW);
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_row_pixels = pix_ff;
   assign rsp_last_row   = last_ff;

endmodule
`default_nettype wire

FILE: src/intra_4x4_predictor_core.sv
`default_nettype none
// 4x4 intra predictor. A transaction is taken when start is high and busy is
// low; it carries the mode, the corner pixel, eight above pixels and four left
// pixels. The predicted block comes back as four row transactions, rows 0..3
// on consecutive cycles, the first on the ports once the request has passed the
// request holding register and the output register of the merge stage,
// each shown for exactly one cycle with rsp_strobe high and rsp_last_row set on
// row 3. The receiver cannot stall: every strobed row must be taken in its
// cycle. Four column lanes produce one full row per cycle; busy is high after
// a request is taken and drops while the last row is computed, so the next
// request can follow with no gap. Mode codes 10 to 15 produce rows of zero
// pixels.
module intra_4x4_predictor_core import i4p_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [3:0]                  req_mode,
   input  logic [PIX_W-1:0]            req_corner_pixel,
   input  logic [ABOVE_N*PIX_W-1:0]    req_above_pixels,
   input  logic [BLOCK_SIZE*PIX_W-1:0] req_left_pixels,
   output logic                        rsp_strobe,
   output logic [ROW_W-1:0]            rsp_row_index,
   output logic [BLOCK_SIZE*PIX_W-1:0] rsp_row_pixels,
   output logic                        rsp_last_row
);

   localparam int SUM_W = PIX_W + $clog2(2*BLOCK_SIZE) + 1;

   // request holding registers and row sequencer
   req_type          req_ff, req_in;
   logic             active_ff, active_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             accept;

   logic [SUM_W-1:0] dc_sum;
   logic [PIX_W-1:0] dc_val;
   row_ctl_type      ctl;
   logic [BLOCK_SIZE-1:0][PIX_W-1:0] lane_pix;

   // free again while the last row of the current transaction is computed
   assign busy   = active_ff && (row_ff != LAST_ROW);
   assign accept = start && !busy;

   always_comb begin
      req_in    = req_ff;
      active_in = active_ff;
      row_in    = row_ff;
      if (accept) begin
         req_in.mode   = req_mode;
         req_in.corner = req_corner_pixel;
         req_in.above  = req_above_pixels;
         req_in.left   = req_left_pixels;
         active_in     = 1'b1;
         row_in        = '0;
      end else if (active_ff) begin
         if (row_ff == LAST_ROW) begin
            active_in = 1'b0;
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= '0;
      end else begin
         active_ff <= active_in;
         row_ff    <= row_in;
      end
      req_ff <= req_in;
   end

   // dc value shared by all lanes: rounded mean of four above and four left
   always_comb begin
      dc_sum = '0;
      for (int k = 0; k < BLOCK_SIZE; k++) begin
         dc_sum = dc_sum + SUM_W'(req_ff.above[k*PIX_W +: PIX_W])
                         + SUM_W'(req_ff.left[k*PIX_W +: PIX_W]);
      end
   end
   assign dc_val = PIX_W'((dc_sum + SUM_W'(BLOCK_SIZE)) >> 3);

   // one lane per column
   for (genvar g = 0; g < BLOCK_SIZE; g++) begin : g_lane
      i4p_lane #(.COL(g)) u_lane (
         .req   (req_ff),
         .row   (row_ff),
         .dc    (dc_val),
         .pixel (lane_pix[g])
      );
   end

   assign ctl.valid = active_ff;
   assign ctl.row   = row_ff;

   i4p_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .lane_pix       (lane_pix),
      .rsp_strobe     (rsp_strobe),
      .rsp_row_index  (rsp_row_index),
      .rsp_row_pixels (rsp_row_pixels),
      .rsp_last_row   (rsp_last_row)
   );

   // a taken transaction shows row 0 after the request holding and output registers
   a_first_row: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 (rsp_strobe && (rsp_row_index == '0)))
      else $error("row 0 missing after accepted transaction");

   // rows of one transaction follow each other without gaps
   a_row_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_row |=>
         rsp_strobe && (rsp_row_index == ROW_W'($past(rsp_row_index) + ROW_W'(1))))
      else $error("row sequence broken");

   // while busy a row is always on its way
   a_busy_rows: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && !rsp_last_row)
      else $error("busy without row output");

   // last flag matches the row index
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_row == (rsp_row_index == LAST_ROW)))
      else $error("last row flag wrong");

endmodule
`default_nettype wire
